### src/plam_pkg.sv
package plam_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int SCREEN_BITS_DEF     = 16;

  localparam int WORD_W  = 32;
  localparam int ARC_W   = 40;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 16;
  localparam int SCR_W   = 16;
  localparam int MAG_W   = 33;
  localparam int RAD_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 33;
  localparam int QUO_W   = 34;
  localparam int XV_W    = 41;
  localparam int CFG_IDX_W = 3;
  localparam int TOTAL_W = 31;

  localparam logic [WORD_W-1:0] ONE_RAW = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MODE        = 3'd0,
    REG_X_LOW         = 3'd1,
    REG_X_HIGH        = 3'd2,
    REG_Y_LOW         = 3'd3,
    REG_Y_HIGH        = 3'd4,
    REG_SCREEN_ORIGIN = 3'd5,
    REG_SCREEN_CORNER = 3'd6,
    REG_TOTAL_LENGTH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    XM_INDEX = 2'd0,
    XM_ARC   = 2'd1,
    XM_NORM  = 2'd2,
    XM_SPARE = 2'd3
  } x_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQ,
    S_ROOT,
    S_XSEL,
    S_XDIV,
    S_WIN,
    S_MULX,
    S_DSTX,
    S_DIVX,
    S_MULY,
    S_DSTY,
    S_DIVY,
    S_OUT
  } state_t;

endpackage

### src/plam_isqrt.sv
module plam_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [plam_pkg::RAD_W-1:0] radicand,
  output logic                       done,
  output logic [plam_pkg::ROOT_W-1:0] root
);
  import plam_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CAT_W = REM_W + 2;
  localparam int STEPS = RAD_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [CAT_W-1:0] cat;
  logic [CAT_W-1:0] trial;

  assign cat   = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {{(CAT_W-ROOT_W-2){1'b0}}, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (cat >= trial) begin
          rem  <= REM_W'(cat - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(cat);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/plam_divider.sv
module plam_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [plam_pkg::NUM_W-1:0] numer,
  input  logic [plam_pkg::DEN_W-1:0] denom,
  output logic                       done,
  output logic [plam_pkg::QUO_W-1:0] quo,
  output logic                       quo_ovf,
  output logic                       rem_nz
);
  import plam_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem2;

  assign rem2   = {rem, num[NUM_W-1]};
  assign rem_nz = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        num     <= numer;
        den     <= denom;
        rem     <= '0;
        quo     <= '0;
        quo_ovf <= 1'b0;
      end else if (busy) begin
        num     <= {num[NUM_W-2:0], 1'b0};
        quo_ovf <= quo_ovf | quo[QUO_W-1];
        if (rem2 >= {1'b0, den}) begin
          rem <= DEN_W'(rem2 - {1'b0, den});
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= DEN_W'(rem2);
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/polyline_arc_length_plot_mapper.sv
// Each point takes one square root and up to two mapping divisions in index
// and arc length modes; normalized mode adds a division for x. A point outside
// the window ends before the mapping divisions and produces no result.
// A new point is accepted only once the last is done and its result is loaded
// into the output register; the iterative root and divider set the pace.
// Reset (synchronous, active high) restores the default window and clears
// the running length, index, kept count and previous point.
module polyline_arc_length_plot_mapper #(
  parameter int COORD_FRAC_BITS = plam_pkg::COORD_FRAC_BITS_DEF,
  parameter int SCREEN_BITS     = plam_pkg::SCREEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [plam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plam_pkg::WORD_W-1:0]    cfg_data,
  // Input item channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic signed [31:0]             point_z,
  input  logic signed [31:0]             scalar_value,
  input  logic                           first_point,
  // Result item channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    screen_x,
  output logic [15:0]                    screen_y,
  output logic [15:0]                    kept_count
);
  import plam_pkg::*;

  // Configuration registers.
  logic [1:0]               x_mode;
  logic signed [WORD_W-1:0] x_low, x_high, y_low, y_high;
  logic [WORD_W-1:0]        screen_origin, screen_corner;
  logic [TOTAL_W-1:0]       total_length;

  // Polyline state.
  logic signed [WORD_W-1:0] prev_x, prev_y, prev_z;
  logic [ARC_W-1:0]         arc_length;
  logic [IDX_W-1:0]         point_index;
  logic [CNT_W-1:0]         kept_points;

  // Working registers for the item in flight.
  state_t                   state, state_next;
  logic signed [WORD_W-1:0] cur_x, cur_y, cur_z, cur_v;
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               cnt;
  logic [RAD_W-1:0]         acc;
  logic [RAD_W-1:0]         product;
  logic signed [XV_W-1:0]   xv;
  logic [MAG_W-1:0]         xoff, yoff;
  logic [DEN_W-1:0]         xden, yden;
  logic [SCR_W-1:0]         ox, oy, res_x, res_y;
  logic [SCR_W-1:0]         cmag_x, cmag_y;
  logic                     cneg_x, cneg_y;

  // Shared multiplier and iterative units.
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [1:0]        mag_sel;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done, div_ovf, div_nz;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [QUO_W-1:0]  div_quo;

  // Combinational helpers.
  logic signed [MAG_W-1:0] dx, dy, dz;
  logic [ARC_W:0]          arc_sum;
  logic signed [XV_W-1:0]  xlo_ext, xhi_ext;
  logic                    in_win;
  logic signed [SCR_W:0]   cdx, cdy;
  logic [SCR_W-1:0]        cx, cy, map_q;
  logic                    out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign dx = MAG_W'(cur_x) - MAG_W'(prev_x);
  assign dy = MAG_W'(cur_y) - MAG_W'(prev_y);
  assign dz = MAG_W'(cur_z) - MAG_W'(prev_z);

  assign arc_sum = {1'b0, arc_length} + (ARC_W+1)'(root);

  assign xlo_ext = XV_W'(x_low);
  assign xhi_ext = XV_W'(x_high);
  assign in_win  = (xv >= xlo_ext) && (xv <= xhi_ext) &&
                   (cur_v >= y_low) && (cur_v <= y_high);

  // Only the low SCREEN_BITS of each box coordinate take part.
  assign cx  = SCR_W'(screen_corner[SCREEN_BITS-1:0]);
  assign cy  = SCR_W'(screen_corner[16 +: SCREEN_BITS]);
  assign cdx = {1'b0, cx} - {1'b0, SCR_W'(screen_origin[SCREEN_BITS-1:0])};
  assign cdy = {1'b0, cy} - {1'b0, SCR_W'(screen_origin[16 +: SCREEN_BITS])};

  assign map_q = div_quo[SCR_W-1:0];

  // Shared multiplier operand selection; the product is always registered.
  assign mag_sel = (cnt < 3'd3) ? cnt[1:0] : 2'd0;
  always_comb begin
    mul_a = mag[mag_sel];
    mul_b = mag[mag_sel];
    if (state == S_MULX) begin
      mul_a = xoff;
      mul_b = MAG_W'(cmag_x);
    end else if (state == S_MULY) begin
      mul_a = yoff;
      mul_b = MAG_W'(cmag_y);
    end
  end

  // Divider operands: the normalized x, or a mapped screen offset.
  always_comb begin
    div_num = NUM_W'(arc_length) << COORD_FRAC_BITS;
    div_den = DEN_W'(total_length);
    if (state == S_DSTX) begin
      div_num = NUM_W'(product[MAG_W+SCR_W-1:0]);
      div_den = xden;
    end else if (state == S_DSTY) begin
      div_num = NUM_W'(product[MAG_W+SCR_W-1:0]);
      div_den = yden;
    end
  end

  assign sq_start  = (state == S_SQ) && (cnt == 3'd4);
  assign div_start = ((state == S_XSEL) && (x_mode == XM_NORM) && (total_length != '0)) ||
                     ((state == S_DSTX) && (xden != '0)) ||
                     ((state == S_DSTY) && (yden != '0));

  plam_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .done     (sq_done),
    .root     (root)
  );

  plam_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (div_num),
    .denom   (div_den),
    .done    (div_done),
    .quo     (div_quo),
    .quo_ovf (div_ovf),
    .rem_nz  (div_nz)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DIFF;
      S_DIFF: state_next = S_SQ;
      S_SQ:   if (cnt == 3'd4) state_next = S_ROOT;
      S_ROOT: if (sq_done) state_next = S_XSEL;
      S_XSEL: state_next = div_start ? S_XDIV : S_WIN;
      S_XDIV: if (div_done) state_next = S_WIN;
      S_WIN:  state_next = in_win ? S_MULX : S_IDLE;
      S_MULX: state_next = S_DSTX;
      S_DSTX: state_next = (xden != '0) ? S_DIVX : S_MULY;
      S_DIVX: if (div_done) state_next = S_MULY;
      S_MULY: state_next = S_DSTY;
      S_DSTY: state_next = (yden != '0) ? S_DIVY : S_OUT;
      S_DIVY: if (div_done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_mode        <= XM_INDEX;
      x_low         <= '0;
      x_high        <= ONE_RAW;
      y_low         <= '0;
      y_high        <= ONE_RAW;
      screen_origin <= '0;
      screen_corner <= '0;
      total_length  <= TOTAL_W'(ONE_RAW);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_MODE:        x_mode        <= cfg_data[1:0];
        REG_X_LOW:         x_low         <= cfg_data;
        REG_X_HIGH:        x_high        <= cfg_data;
        REG_Y_LOW:         y_low         <= cfg_data;
        REG_Y_HIGH:        y_high        <= cfg_data;
        REG_SCREEN_ORIGIN: screen_origin <= cfg_data;
        REG_SCREEN_CORNER: screen_corner <= cfg_data;
        REG_TOTAL_LENGTH:  total_length  <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Polyline state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      arc_length  <= '0;
      point_index <= '0;
      kept_points <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          // A new polyline starts from its own first point, so that point
          // contributes a zero step.
          if (in_valid && first_point) begin
            prev_x      <= point_x;
            prev_y      <= point_y;
            prev_z      <= point_z;
            arc_length  <= '0;
            point_index <= '0;
            kept_points <= '0;
          end
        end
        S_DIFF: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          prev_z <= cur_z;
        end
        S_ROOT: begin
          if (sq_done) arc_length <= arc_sum[ARC_W] ? '1 : arc_sum[ARC_W-1:0];
        end
        S_XSEL: begin
          if (point_index != '1) point_index <= point_index + 1'b1;
        end
        S_WIN: begin
          if (in_win && (kept_points != '1)) kept_points <= kept_points + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers for the item in flight.
  always_ff @(posedge clk) begin
    product <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        cur_x <= point_x;
        cur_y <= point_y;
        cur_z <= point_z;
        cur_v <= scalar_value;
      end
      S_DIFF: begin
        mag[0] <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        mag[1] <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        mag[2] <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
        cnt    <= '0;
        acc    <= '0;
      end
      S_SQ: begin
        // Each square comes out of the registered multiplier in the cycle after its operands.
        if (cnt != 3'd0 && cnt != 3'd4) acc <= acc + product;
        if (cnt != 3'd4) cnt <= cnt + 1'b1;
      end
      S_XSEL: begin
        unique case (x_mode_t'(x_mode))
          XM_INDEX: xv <= XV_W'({1'b0, (ARC_W'(point_index) << COORD_FRAC_BITS)});
          XM_NORM:  xv <= (total_length == '0) ? xlo_ext : XV_W'(0);
          default:  xv <= XV_W'({1'b0, arc_length});
        endcase
      end
      S_XDIV: begin
        // Huge quotients clamp to 2^32, which is always outside the window.
        if (div_done) begin
          if (div_ovf || (div_quo > QUO_W'(64'h1_0000_0000)))
            xv <= XV_W'(64'h1_0000_0000);
          else
            xv <= XV_W'(div_quo);
        end
      end
      S_WIN: begin
        xoff   <= MAG_W'(xv - xlo_ext);
        yoff   <= MAG_W'(cur_v) - MAG_W'(y_low);
        xden   <= MAG_W'(x_high) - MAG_W'(x_low);
        yden   <= MAG_W'(y_high) - MAG_W'(y_low);
        ox     <= SCR_W'(screen_origin[SCREEN_BITS-1:0]);
        oy     <= SCR_W'(screen_origin[16 +: SCREEN_BITS]);
        cneg_x <= cdx[SCR_W];
        cneg_y <= cdy[SCR_W];
        cmag_x <= cdx[SCR_W] ? SCR_W'(-cdx) : SCR_W'(cdx);
        cmag_y <= cdy[SCR_W] ? SCR_W'(-cdy) : SCR_W'(cdy);
      end
      S_DSTX: begin
        if (xden == '0) res_x <= ox;
      end
      S_DIVX: begin
        // A shrinking axis rounds toward minus infinity.
        if (div_done) res_x <= cneg_x ? (ox - map_q - SCR_W'(div_nz)) : (ox + map_q);
      end
      S_DSTY: begin
        if (yden == '0) res_y <= oy;
      end
      S_DIVY: begin
        if (div_done) res_y <= cneg_y ? (oy - map_q - SCR_W'(div_nz)) : (oy + map_q);
      end
      default: ;
    endcase
    if (out_load) begin
      screen_x   <= res_x;
      screen_y   <= res_y;
      kept_count <= kept_points;
    end
  end

endmodule

### src/plam_checker.sv
module plam_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] screen_x,
  input logic [15:0] kept_count
);

  // A result that is offered is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(kept_count))
    else $error("result item dropped or changed while stalled");

  // After reset nothing is offered.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // One point at a time: accepting a point closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a point is in flight");

  // Every kept point carries a count of at least one.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kept_count != 16'd0)
    else $error("result item with zero kept count");

  // A result cannot appear in the cycle right after an accept.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without computation");

endmodule

bind polyline_arc_length_plot_mapper plam_checker u_plam_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .screen_x   (screen_x),
  .kept_count (kept_count)
);
